/* hdl/bfde_pkg.sv */
// Package for the bitplane framebuffer draw engine.
// Holds payload structs, command and color codes, controller states and
// the controller-to-datapath command struct. Depends on nothing.
package bfde_pkg;

  typedef enum logic [2:0] {
    CMD_POINT = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_RECT  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_BLACK = 2'd1,
    COL_RED   = 2'd2,
    COL_NONE  = 2'd3
  } color_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  span;
    logic [7:0]  height_span;
    logic        vertical;
    logic        solid;
    logic [1:0]  color;
    logic [1:0]  fill_color;
    logic [11:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] first_plane_byte;
    logic [7:0] second_plane_byte;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SEG_SETUP,
    ST_PIX_READ,
    ST_PIX_WAIT,
    ST_PIX_WRITE,
    ST_CLEAR,
    ST_READ_WAIT,
    ST_READ_DONE,
    ST_RESULT
  } state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       load_seg;    // latch segment start, length, direction, color
    logic [7:0] seg_x;
    logic [7:0] seg_y;
    logic [7:0] seg_len;
    logic       seg_vert;
    logic [1:0] seg_color;
    logic       rd_pix;      // read the byte under the current pixel
    logic       wr_pix;      // write the modified byte, advance the pixel
    logic       clr_start;   // begin a clear sweep
    logic       clr_step;    // write one byte of the clear sweep
    logic       rd_byte;     // read a byte for the read command
    logic [11:0] rd_index;
  } dp_cmd_t;

  typedef struct packed {
    logic        seg_done;   // no pixels left in the segment
    logic        pix_skip;   // current pixel lies off screen or past the planes
    logic        clr_done;   // sweep counter at the last byte
    logic [7:0]  rd_black;
    logic [7:0]  rd_red;
  } dp_stat_t;

endpackage

/* hdl/bitplane_framebuffer_draw_engine_unit.sv */
// Channel   Signals                         Payload
// in        in_valid_i / in_ready_o         in_item_i  (in_item_t)
// out       out_valid_o / out_ready_i       out_item_o (out_item_t)
//
// One item at a time. From accept, a rejected item goes from decode to its result,
// a read adds two memory states, a point is a one-pixel line, a line walks each
// pixel through read, wait and write, plus one pass. Rectangle: decode, result,
// and per edge or fill row a setup and its pixel walk. Clear screen writes a byte
// a cycle. A waiting result lets the next item in, but that item holds in its
// result state and stalls input. Reset sweeps both planes to white, input held off.
module bitplane_framebuffer_draw_engine_unit import bfde_pkg::*; #(
  parameter int ROW_BYTES = 13,
  parameter int X_LIMIT   = 103,
  parameter int Y_LIMIT   = 211,
  parameter int ROWS      = 212
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfde_controller #(.ROW_BYTES(ROW_BYTES), .X_LIMIT(X_LIMIT), .Y_LIMIT(Y_LIMIT),
                    .ROWS(ROWS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o, .cmd_o(cmd), .stat_i(stat)
  );

  bfde_datapath #(.ROW_BYTES(ROW_BYTES), .X_LIMIT(X_LIMIT), .Y_LIMIT(Y_LIMIT),
                  .ROWS(ROWS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat)
  );

endmodule

/* hdl/bfde_datapath.sv */
// Datapath: the two plane memories, the segment pixel walker and the
// clear sweep counter. Depends on bfde_pkg.
module bfde_datapath import bfde_pkg::*; #(
  parameter int ROW_BYTES = 13,
  parameter int X_LIMIT   = 103,
  parameter int Y_LIMIT   = 211,
  parameter int ROWS      = 212
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o
);

  localparam int PlaneBytes = ROW_BYTES * ROWS;
  localparam int AW = $clog2(PlaneBytes);

  logic [7:0] black_mem [PlaneBytes];
  logic [7:0] red_mem   [PlaneBytes];

  logic [7:0] px_q, px_d, py_q, py_d, left_q, left_d;
  logic       vert_q;
  logic [1:0] col_q;
  logic [AW:0] clr_q, clr_d;
  logic [7:0] clr_black_q, clr_red_q;
  logic [7:0] rb_q, rr_q;

  logic [12:0] pix_idx;
  logic [AW-1:0] pix_addr, clr_addr, rd_addr, mem_addr;
  logic [7:0] mask, nb, nr;
  logic       we;
  logic [7:0] wb, wr;

  assign pix_idx  = 13'(py_q) * 13'(ROW_BYTES) + 13'(px_q[7:3]);
  assign pix_addr = pix_idx[AW-1:0];
  assign clr_addr = clr_q[AW-1:0];
  assign rd_addr  = cmd_i.rd_index[AW-1:0];
  assign mask     = 8'h80 >> px_q[2:0];

  always_comb begin
    nb = rb_q;
    nr = rr_q;
    case (col_q)
      COL_WHITE: begin nb = rb_q & ~mask; nr = rr_q & ~mask; end
      COL_BLACK: begin nb = rb_q | mask;  nr = rr_q & ~mask; end
      COL_RED:   begin nb = rb_q & ~mask; nr = rr_q | mask;  end
      default:   ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wb = nb;
    wr = nr;
    mem_addr = pix_addr;
    if (cmd_i.clr_step) begin
      we = 1'b1;
      wb = clr_black_q;
      wr = clr_red_q;
      mem_addr = clr_addr;
    end else if (cmd_i.wr_pix) begin
      we = ~stat_o.pix_skip;
    end else if (cmd_i.rd_byte) begin
      mem_addr = rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      black_mem[mem_addr] <= wb;
      red_mem[mem_addr]   <= wr;
    end
    rb_q <= black_mem[mem_addr];
    rr_q <= red_mem[mem_addr];
  end

  always_comb begin
    px_d = px_q;
    py_d = py_q;
    left_d = left_q;
    clr_d = clr_q;
    if (cmd_i.load_seg) begin
      px_d = cmd_i.seg_x;
      py_d = cmd_i.seg_y;
      left_d = cmd_i.seg_len;
    end else if (cmd_i.wr_pix) begin
      left_d = left_q - 8'd1;
      if (vert_q) py_d = py_q + 8'd1;
      else px_d = px_q + 8'd1;
    end
    if (cmd_i.clr_start) clr_d = '0;
    else if (cmd_i.clr_step) clr_d = clr_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      left_q <= '0;
      vert_q <= 1'b0;
      col_q <= COL_NONE;
      clr_q <= '0;
      clr_black_q <= '0;
      clr_red_q <= '0;
    end else begin
      px_q <= px_d;
      py_q <= py_d;
      left_q <= left_d;
      clr_q <= clr_d;
      if (cmd_i.load_seg) begin
        vert_q <= cmd_i.seg_vert;
        col_q  <= cmd_i.seg_color;
      end
      if (cmd_i.clr_start) begin
        clr_black_q <= {8{cmd_i.seg_color == COL_BLACK}};
        clr_red_q   <= {8{cmd_i.seg_color == COL_RED}};
      end
    end
  end

  assign stat_o.seg_done = (left_q == 8'd0);
  assign stat_o.pix_skip = (32'(px_q) > X_LIMIT) || (32'(py_q) > Y_LIMIT) ||
                           (32'(pix_idx) >= PlaneBytes);
  assign stat_o.clr_done = (32'(clr_q) == PlaneBytes - 1);
  assign stat_o.rd_black = rb_q;
  assign stat_o.rd_red   = rr_q;

endmodule

/* hdl/bfde_controller.sv */
// Controller: decodes commands, checks ranges, sequences rectangle edges
// and fill rows into line segments. Depends on bfde_pkg.
module bfde_controller import bfde_pkg::*; #(
  parameter int ROW_BYTES = 13,
  parameter int X_LIMIT   = 103,
  parameter int Y_LIMIT   = 211,
  parameter int ROWS      = 212
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  output dp_cmd_t   cmd_o,
  input  dp_stat_t  stat_i
);

  localparam int PlaneBytes = ROW_BYTES * ROWS;

  state_e state_q, state_d;
  in_item_t it_q;
  logic [2:0] seg_q, seg_d;     // 0..3 edges, 4 fill rows
  logic [7:0] row_q, row_d;
  logic [7:0] rows_left_q, rows_left_d;
  out_item_t res_q, res_d;
  logic       ov_q, ov_d;

  logic [7:0] sx, sy, sl;
  logic       sv;
  logic [1:0] sc;
  logic       s_ok;
  logic       rej;
  logic [7:0] side, inner;

  assign side  = it_q.height_span - 8'd2;
  assign inner = it_q.span - 8'd2;

  // Rejection test for the accepted command.
  always_comb begin
    logic [8:0] ex, ey;
    ex = 9'(it_q.x) + 9'(it_q.span);
    ey = 9'(it_q.y) + 9'(it_q.height_span);
    rej = 1'b0;
    case (it_q.cmd)
      CMD_POINT: rej = 32'(it_q.x) > X_LIMIT || 32'(it_q.y) > Y_LIMIT;
      CMD_LINE:  rej = 32'(it_q.x) > X_LIMIT || 32'(it_q.y) > Y_LIMIT ||
                       (!it_q.vertical && 32'(ex) > X_LIMIT + 1) ||
                       (it_q.vertical && 32'(ey - 9'(it_q.height_span) +
                        9'(it_q.span)) > Y_LIMIT + 1);
      CMD_RECT:  rej = 32'(it_q.x) > X_LIMIT || 32'(it_q.y) > Y_LIMIT ||
                       32'(ex) > X_LIMIT + 1 || 32'(ey) > Y_LIMIT + 1;
      CMD_CLEAR: rej = 1'b0;
      CMD_READ:  rej = 32'(it_q.read_index) >= PlaneBytes;
      default:   rej = 1'b1;
    endcase
  end

  // Current segment of the command.
  always_comb begin
    sx = it_q.x; sy = it_q.y; sl = it_q.span; sv = it_q.vertical; sc = it_q.color;
    case (it_q.cmd)
      CMD_POINT: sl = 8'd1;
      CMD_RECT: begin
        case (seg_q)
          3'd0: sv = 1'b0;
          3'd1: begin sv = 1'b0; sy = it_q.y + it_q.height_span - 8'd1; end
          3'd2: begin sv = 1'b1; sy = it_q.y + 8'd1; sl = side; end
          3'd3: begin
            sv = 1'b1; sx = it_q.x + it_q.span - 8'd1;
            sy = it_q.y + 8'd1; sl = side;
          end
          default: begin
            sv = 1'b0; sx = it_q.x + 8'd1; sy = row_q; sl = inner;
            sc = it_q.fill_color;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Silent drop for rectangle sub-lines that fall off screen.
  always_comb begin
    logic [8:0] e;
    e = sv ? 9'(sy) + 9'(sl) : 9'(sx) + 9'(sl);
    s_ok = !(32'(sx) > X_LIMIT || 32'(sy) > Y_LIMIT ||
             (!sv && 32'(e) > X_LIMIT + 1) || (sv && 32'(e) > Y_LIMIT + 1));
  end

  always_comb begin
    state_d = state_q;
    seg_d = seg_q;
    row_d = row_q;
    rows_left_d = rows_left_q;
    res_d = res_q;
    ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      ST_INIT: if (stat_i.clr_done) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        seg_d = '0;
        row_d = it_q.y + 8'd1;
        rows_left_d = it_q.height_span - 8'd2;
        res_d = '{status: rej, first_plane_byte: 8'd0, second_plane_byte: 8'd0};
        if (rej) state_d = ST_RESULT;
        else if (it_q.cmd == CMD_CLEAR) state_d = (it_q.color == COL_NONE) ? ST_RESULT
                                                                           : ST_CLEAR;
        else if (it_q.cmd == CMD_READ) state_d = ST_READ_WAIT;
        else state_d = ST_SEG_SETUP;
      end
      ST_SEG_SETUP: begin
        // rows_left would wrap for h<2: the h<3 test gives no fill rows
        if (seg_q == 3'd4 && (!it_q.solid || it_q.height_span < 8'd3 ||
                              rows_left_q == 8'd0)) begin
          state_d = ST_RESULT;
        end else if (s_ok && sl != 8'd0) begin
          state_d = ST_PIX_READ;
        end else begin
          state_d = ST_PIX_WRITE;  // empty segment, advance directly
        end
      end
      ST_PIX_READ:  state_d = ST_PIX_WAIT;
      ST_PIX_WAIT:  state_d = ST_PIX_WRITE;
      ST_PIX_WRITE: begin
        if (stat_i.seg_done) begin
          if (it_q.cmd != CMD_RECT) state_d = ST_RESULT;
          else begin
            if (seg_q == 3'd4) begin
              row_d = row_q + 8'd1;
              rows_left_d = rows_left_q - 8'd1;
            end else seg_d = seg_q + 3'd1;
            state_d = ST_SEG_SETUP;
          end
        end else begin
          state_d = ST_PIX_READ;
        end
      end
      ST_CLEAR:     if (stat_i.clr_done) state_d = ST_RESULT;
      ST_READ_WAIT: state_d = ST_READ_DONE;
      ST_READ_DONE: begin
        res_d.first_plane_byte  = stat_i.rd_black;
        res_d.second_plane_byte = stat_i.rd_red;
        state_d = ST_RESULT;
      end
      ST_RESULT: if (!ov_q || out_ready_i) begin
        ov_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.seg_x = sx;
    cmd_o.seg_y = sy;
    cmd_o.seg_len = (s_ok) ? sl : 8'd0;
    cmd_o.seg_vert = sv;
    cmd_o.seg_color = sc;
    cmd_o.rd_index = it_q.read_index;
    unique case (state_q)
      ST_DECODE: begin
        cmd_o.clr_start = 1'b1;
        cmd_o.seg_color = it_q.color;
        cmd_o.rd_byte = (it_q.cmd == CMD_READ);
      end
      ST_SEG_SETUP: cmd_o.load_seg = 1'b1;
      ST_PIX_READ:  cmd_o.rd_pix = 1'b1;
      ST_PIX_WRITE: cmd_o.wr_pix = !stat_i.seg_done;
      // the sweep after reset writes white, as the clear registers reset to it
      ST_CLEAR, ST_INIT: cmd_o.clr_step = 1'b1;
      ST_READ_WAIT: cmd_o.rd_byte = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      seg_q <= '0;
      row_q <= '0;
      rows_left_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seg_q <= seg_d;
      row_q <= row_d;
      rows_left_q <= rows_left_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) it_q <= in_item_i;
    res_q <= res_d;
    if (state_q == ST_RESULT && (!ov_q || out_ready_i)) out_item_o <= res_q;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;

endmodule

/* hdl/bfde_checker.sv */
// Port-level checker for the draw engine, bound to the top level.
// Depends on bfde_pkg.
module bfde_port_checker import bfde_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status |-> out_item_o.first_plane_byte == 8'd0)
    else $error("rejected item carries data");
endmodule

bind bitplane_framebuffer_draw_engine_unit bfde_port_checker u_chk (.*);
